>>> hw/rtl/record_sort_by_price_defines.svh
// Assertion helpers used by the checker in rsbp_check.sv.
`ifndef RECORD_SORT_BY_PRICE_DEFINES_SVH
`define RECORD_SORT_BY_PRICE_DEFINES_SVH

// Clocked assertion, quiet while reset is applied.
`define RSBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error(msg);

// Clocked check that a condition never occurs.
`define RSBP_NEVER(label, cond, msg) \
  `RSBP_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/rsbp_pkg.sv
package rsbp_pkg;

  typedef struct packed {
    logic [31:0] price;
    logic [47:0] item_code;
  } rec_in_t;

  typedef struct packed {
    logic [31:0] sorted_price;
    logic [47:0] sorted_code;
    logic        last_record;
  } rec_out_t;

  // Stored record: price is the sort key, code rides along.
  typedef struct packed {
    logic [31:0] price;
    logic [47:0] code;
  } rec_t;

  localparam int RecW = $bits(rec_t);

endpackage

>>> hw/rtl/rsbp_ram.sv
module rsbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/record_sort_by_price.sv
// Records are loaded one per cycle while busy is low. Once the last record of a set is
// taken, the set is sorted in place, then the sorted records are read out in order, one
// per cycle. A new set is taken only after the sort and readout of the last one. The
// single read port of the record RAM feeds one compare per cycle during the inner scan.
// Results cannot be stalled. Reset (async, active low) returns to loading with an
// empty set.
module record_sort_by_price #(
  parameter int RECORD_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rsbp_pkg::rec_in_t  item_i,
  output logic               busy_o,
  output logic               out_strobe_o,
  output rsbp_pkg::rec_out_t result_o
);
  import rsbp_pkg::*;

  localparam int IdxW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RECORD_COUNT - 1);
  localparam logic [IdxW-1:0] IdxOne  = IdxW'(1);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,  // take records from the input side
    ST_FETCH = 7'b0000010,  // read the outer record a
    ST_LATCH = 7'b0000100,  // hold record a in held_q
    ST_SCAN  = 7'b0001000,  // read inner records b, one per cycle
    ST_DRAIN = 7'b0010000,  // compare of the last inner record
    ST_WB    = 7'b0100000,  // write held record back to slot a
    ST_EMIT  = 7'b1000000   // read sorted records out in order
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] load_q, load_d;     // records stored in the current set
  logic [IdxW-1:0] a_q, a_d;           // outer sort index
  logic [IdxW-1:0] b_q, b_d;           // inner sort index, reused as emit index
  logic [IdxW-1:0] cmp_idx_q;          // slot whose read data arrives this cycle
  logic            cmp_v_q;            // read data of cmp_idx_q is valid
  logic            emit_v_q;
  logic            emit_last_q;
  rec_t            held_q, held_d;     // live copy of record a during its inner loop

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  rec_t            ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  rec_t            ram_rdata;
  logic            swap;

  // Record a sits in held_q while b sweeps the set; slot a itself in the RAM
  // is stale then, so skip it. On a swap, the inner record takes a's value and
  // held_q takes the inner record - the same as the in-place exchange.
  assign swap = cmp_v_q && (cmp_idx_q != a_q) && (held_q.price < ram_rdata.price);

  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    a_d       = a_q;
    b_d       = b_q;
    held_d    = held_q;
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_q;
    ram_wdata = held_q;
    ram_raddr = b_q;

    if (swap) begin
      ram_we = 1'b1;
      held_d = ram_rdata;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (start_i) begin
          // store the beat; the last record of a set kicks off the sort
          ram_we    = 1'b1;
          ram_waddr = load_q;
          ram_wdata = '{price: item_i.price, code: item_i.item_code};
          if (load_q == LastIdx) begin
            load_d  = '0;
            a_d     = '0;
            state_d = ST_FETCH;
          end else begin
            load_d = load_q + IdxOne;
          end
        end
      end
      ST_FETCH: begin
        ram_raddr = a_q;
        state_d   = ST_LATCH;
      end
      ST_LATCH: begin
        held_d  = ram_rdata;
        b_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // issue one inner read per cycle; its compare lands next cycle
        ram_raddr = b_q;
        if (b_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          b_d = b_q + IdxOne;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = held_q;
        if (a_q == LastIdx) begin
          b_d     = '0;
          state_d = ST_EMIT;
        end else begin
          a_d     = a_q + IdxOne;
          state_d = ST_FETCH;
        end
      end
      ST_EMIT: begin
        // advance through the sorted set; the RAM read register drives the beat
        ram_raddr = b_q;
        if (b_q == LastIdx) begin
          state_d = ST_LOAD;
        end else begin
          b_d = b_q + IdxOne;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_q      <= '0;
      a_q         <= '0;
      b_q         <= '0;
      cmp_v_q     <= 1'b0;
      emit_v_q    <= 1'b0;
      emit_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      a_q         <= a_d;
      b_q         <= b_d;
      cmp_v_q     <= (state_q == ST_SCAN);
      emit_v_q    <= (state_q == ST_EMIT);
      emit_last_q <= (state_q == ST_EMIT) && (b_q == LastIdx);
    end
  end

  // Payload only: no reset.
  always_ff @(posedge clk_i) begin
    held_q    <= held_d;
    cmp_idx_q <= b_q;
  end

  rsbp_ram #(
    .Width (RecW),
    .Depth (RECORD_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o                = (state_q != ST_LOAD);
  assign out_strobe_o          = emit_v_q;
  assign result_o.sorted_price = ram_rdata.price;
  assign result_o.sorted_code  = ram_rdata.code;
  assign result_o.last_record  = emit_last_q;

endmodule

>>> hw/rtl/rsbp_check.sv
`include "record_sort_by_price_defines.svh"

module rsbp_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               out_strobe_o,
  input rsbp_pkg::rec_out_t result_o
);
  import rsbp_pkg::*;

  // A sorted run goes out without gaps.
  `RSBP_ASSERT(a_run_contiguous, out_strobe_o && !result_o.last_record |=> out_strobe_o, "gap in sorted run")
  // Nothing follows the final beat of a run.
  `RSBP_ASSERT(a_last_ends_run, out_strobe_o && result_o.last_record |=> !out_strobe_o, "beat after last record")
  // Loading a record never produces a result in the next cycle.
  `RSBP_ASSERT(a_load_quiet, start_i && !busy_o |=> !out_strobe_o, "result right after a load beat")
  // Every beat but the last is shown while the block is busy.
  `RSBP_NEVER(a_emit_busy, out_strobe_o && !result_o.last_record && !busy_o, "result while idle")

endmodule

bind record_sort_by_price rsbp_check u_rsbp_check (.*);

>>> tb/record_sort_by_price_tb.sv
module record_sort_by_price_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsbp_pkg::*;

  localparam int REC_COUNT = 8;
  // Drain window after the last expected record: one full sort plus output and slack.
  localparam int DRAIN_CYCLES = REC_COUNT * (REC_COUNT + 6) + REC_COUNT + 20;
  // Generous cap on the whole run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_CAP = 10;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  rec_in_t  item_i = '0;
  logic     busy_o;
  logic     out_strobe_o;
  rec_out_t result_o;

  record_sort_by_price #(
    .RECORD_COUNT(REC_COUNT)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .out_strobe_o(out_strobe_o),
    .result_o    (result_o)
  );

  // 12 ns period clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Sort predictor: collect records of the current set, run the same exchange
  // pass as the block (swap i/j when price[i] < price[j], i outer, j inner) on
  // the completing beat, and queue the sorted records in output order.
  // ---------------------------------------------------------------------------
  rec_t     set_buf [REC_COUNT];
  int       set_fill = 0;
  rec_out_t sorted_queue [$];

  int error_count = 0;
  int cycle_count = 0;

  task automatic load_record(input rec_in_t beat);
    rec_t     tmp;
    rec_out_t exp_rec;
    set_buf[set_fill].price = beat.price;
    set_buf[set_fill].code  = beat.item_code;
    set_fill++;
    if (set_fill == REC_COUNT) begin
      for (int a = 0; a < REC_COUNT; a++) begin
        for (int b = 0; b < REC_COUNT; b++) begin
          if (set_buf[a].price < set_buf[b].price) begin
            tmp        = set_buf[a];
            set_buf[a] = set_buf[b];
            set_buf[b] = tmp;
          end
        end
      end
      for (int k = 0; k < REC_COUNT; k++) begin
        exp_rec.sorted_price = set_buf[k].price;
        exp_rec.sorted_code  = set_buf[k].code;
        exp_rec.last_record  = (k == REC_COUNT - 1);
        sorted_queue.push_back(exp_rec);
      end
      set_fill = 0;
    end
  endtask

  // Count every failure, print only the first few.
  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_CAP) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. Outputs are sampled at the rising edge, so we see the
  // values of the cycle that this edge ends; each strobe is one result beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rec_out_t exp_rec;
    if (rst_ni && out_strobe_o) begin
      if (sorted_queue.size() == 0) begin
        flag_error($sformatf("unexpected result price=%h code=%h last=%b",
                             result_o.sorted_price, result_o.sorted_code,
                             result_o.last_record));
      end else begin
        exp_rec = sorted_queue.pop_front();
        if (result_o.sorted_price !== exp_rec.sorted_price ||
            result_o.sorted_code  !== exp_rec.sorted_code  ||
            result_o.last_record  !== exp_rec.last_record) begin
          flag_error($sformatf({"result mismatch: exp price=%h code=%h last=%b, ",
                                "got price=%h code=%h last=%b"},
                               exp_rec.sorted_price, exp_rec.sorted_code,
                               exp_rec.last_record, result_o.sorted_price,
                               result_o.sorted_code, result_o.last_record));
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("record_sort_by_price_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; drive the beat, then hold it until an
  // edge samples busy low. Start stays high on return so a follow-on beat
  // does not drop and re-raise it in the same time step.
  // ---------------------------------------------------------------------------
  task automatic send_record(input logic [31:0] price, input logic [47:0] code);
    rec_in_t beat;
    beat.price     = price;
    beat.item_code = code;
    start_i <= 1'b1;
    item_i  <= beat;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    load_record(beat);
  endtask

  // Idle the sender with the given odds; mostly short gaps, now and then a
  // long one so that gaps also land inside the sort and the output burst.
  task automatic sender_gap(input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(20, 120)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  endtask

  // Random price: ties from a tiny pool, the extremes, or any 32-bit word.
  function automatic logic [31:0] pick_price();
    case ($urandom_range(7))
      0, 1:    return {14'd0, 2'($urandom_range(3)), 16'd0};
      2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick_code();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic run_random_sets(input int n_sets, input int idle_pct);
    for (int s = 0; s < n_sets; s++) begin
      for (int r = 0; r < REC_COUNT; r++) begin
        sender_gap(idle_pct);
        send_record(pick_price(), pick_code());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Field extremes: zero and all-ones prices and codes, sign-bit neighbors,
  // a duplicate zero price.
  task automatic test_extremes();
    send_record(32'h0000_0000, 48'h0000_0000_0000);
    send_record(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_record(32'h0000_0001, 48'h4142_4344_4546);
    send_record(32'hFFFF_FFFE, 48'h5A5A_5A5A_5A5A);
    send_record(32'h0001_0000, 48'h4F4E_4531_3233);
    send_record(32'h8000_0000, 48'h8000_0000_0000);
    send_record(32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_record(32'h0000_0000, 48'h0000_0000_0001);
  endtask

  // All prices equal: the exchange pass alone decides the code order.
  task automatic test_equal_prices();
    for (int k = 0; k < REC_COUNT; k++) begin
      send_record(32'h0005_0000, 48'h4954_454D_3030 + 48'(k));
    end
  endtask

  // Descending prices with runs of ties.
  task automatic test_descending_ties();
    logic [31:0] prices [REC_COUNT] = '{32'hFFFF_0000, 32'hFFFF_0000, 32'h0002_0000,
                                       32'h0002_0000, 32'h0001_0000, 32'h0000_8000,
                                       32'h0000_8000, 32'h0000_0000};
    for (int k = 0; k < REC_COUNT; k++) begin
      send_record(prices[k], 48'h4445_5343_3030 + 48'(k));
    end
  endtask

  // Random sets with no idling.
  task automatic test_random_back_to_back();
    run_random_sets(10, 0);
  endtask

  // Random sets, sender idle most of the time.
  task automatic test_random_heavy_gaps();
    run_random_sets(12, 65);
  endtask

  // Random sets, light idling.
  task automatic test_random_light_gaps();
    run_random_sets(10, 22);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_equal_prices();
    test_descending_ties();
    test_random_back_to_back();
    test_random_heavy_gaps();
    test_random_light_gaps();

    // Drop start, wait out the expected records, then watch for strays.
    start_i <= 1'b0;
    while (sorted_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sorted_queue.size() != 0) begin
      flag_error($sformatf("%0d expected records never arrived", sorted_queue.size()));
    end

    if (error_count == 0) begin
      $display("record_sort_by_price_tb passed");
    end else begin
      $display("record_sort_by_price_tb failed");
    end
    $finish;
  end

endmodule

>>> record_sort_by_price.f
+incdir+hw/rtl
hw/rtl/rsbp_pkg.sv
hw/rtl/rsbp_ram.sv
hw/rtl/record_sort_by_price.sv
hw/rtl/rsbp_check.sv
tb/record_sort_by_price_tb.sv
